/* hdl/stq_pkg.sv */
`default_nettype none

package stq_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned StatusW = 2;
  localparam int unsigned MaxExp  = 32;
  localparam int unsigned ExpCntW = 6;

  localparam logic [CmdW-1:0] CmdArm    = 2'd0;
  localparam logic [CmdW-1:0] CmdRearm  = 2'd1;
  localparam logic [CmdW-1:0] CmdCancel = 2'd2;
  localparam logic [CmdW-1:0] CmdTick   = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StArmed    = 2'd1;
  localparam logic [StatusW-1:0] StNotArmed = 2'd2;
  localparam logic [StatusW-1:0] StFired    = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StInsRd,
    StInsChk,
    StCanRd,
    StCanChk,
    StTickRd,
    StTickChk
  } state_e;

endpackage

`default_nettype wire

/* hdl/sorted_timeout_queue_core.sv */
// Sorted timeout queue: SLOTS timeout slots kept in wakeup order.
// Command channel: a beat is taken at a clock edge with start high and busy
// low (cmd_i, slot_i, wakeup_time_i, now_i). Commands: arm, re-arm with the
// stored time, cancel, tick.
// Result channel: each result beat is shown for one cycle with result_valid_o
// high; last_o marks the final beat of a command. The receiver cannot stall;
// results are never held back.
// Timing: the slot's stored time is read first, then the order list in
// a one-port-read memory is walked one entry at a time (read, then
// compare and write back). A rejected command or a tick that expires
// nothing ends in the decode state; arm or re-arm walks from the tail over
// the entries with a time equal or later; cancel walks the whole list; a
// tick walks the list once per expired slot, since the list shifts down by
// one entry after each expiry (at most 32 per tick). Each result beat shows
// the cycle after it is formed; the next command may be taken in the cycle
// the last beat is shown.
// Reset: all slots unarmed and not fired, list empty; stored times and list
// contents are undefined until written and need no clearing pass.
`default_nettype none

module sorted_timeout_queue_core #(
  parameter int unsigned SLOTS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [stq_pkg::CmdW-1:0]         cmd_i,
  input  wire logic [stq_pkg::SlotW-1:0]        slot_i,
  input  wire logic [stq_pkg::TimeW-1:0]        wakeup_time_i,
  input  wire logic [stq_pkg::TimeW-1:0]        now_i,
  output logic                                  result_valid_o,
  output logic [stq_pkg::StatusW-1:0]           status_o,
  output logic                                  expired_valid_o,
  output logic [stq_pkg::SlotW-1:0]             expired_slot_o,
  output logic                                  last_o,
  output logic                                  head_valid_o,
  output logic [stq_pkg::TimeW-1:0]             head_wakeup_o,
  output logic                                  head_changed_o,
  output logic                                  slot_armed_o,
  output logic                                  slot_fired_o,
  output logic signed [stq_pkg::TimeW-1:0]      remaining_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TW = stq_pkg::TimeW;
  localparam int unsigned EW = IW + TW;

  stq_pkg::state_e state_q, state_d;

  // memories
  logic [TW-1:0] wake_mem [SLOTS];
  logic [EW-1:0] ord_mem  [SLOTS];
  logic [TW-1:0] wake_rd_q;
  logic [EW-1:0] ord_rd_q;

  logic          wk_re, wk_we;
  logic [IW-1:0] wk_raddr;
  logic          ord_re, ord_we;
  logic [IW-1:0] ord_raddr, ord_waddr;
  logic [EW-1:0] ord_wdata;

  // command registers
  logic [stq_pkg::CmdW-1:0]  cmd_q;
  logic [stq_pkg::SlotW-1:0] slot_q;
  logic [TW-1:0]             wt_q, now_q;

  // walk state
  logic [TW-1:0]               t_q, t_d;
  logic [CW-1:0]               pos_q, pos_d;
  logic                        found_q, found_d;
  logic                        p0_q, p0_d;
  logic [stq_pkg::ExpCntW-1:0] n_q, n_d;
  logic [IW-1:0]               exp_slot_q, exp_slot_d;
  logic [TW-1:0]               exp_time_q, exp_time_d;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [IW-1:0]      head_slot_q, head_slot_d;
  logic [TW-1:0]      head_time_q, head_time_d;
  logic [SLOTS-1:0]   armed_q, armed_d, fired_q, fired_d;

  // result
  logic                         res_v_d;
  logic [stq_pkg::StatusW-1:0]  res_status_d;
  logic                         res_ev_d, res_last_d, res_hc_d, res_hv_d;
  logic [stq_pkg::SlotW-1:0]    res_es_d;
  logic [TW-1:0]                res_hw_d;
  logic                         res_sa_d, res_sf_d;
  logic [TW-1:0]                res_rem_d;

  logic          accept;
  logic [IW-1:0] sidx;
  logic          inrange;
  logic [IW-1:0] ent_slot;
  logic [TW-1:0] ent_time;
  logic [CW-1:0] cnt_m1;
  logic          tick_due;
  logic          last_exp;

  assign accept   = start && !busy;
  assign busy     = (state_q != stq_pkg::StIdle);
  assign sidx     = IW'(slot_q);
  assign inrange  = (32'(slot_q) < SLOTS);
  assign ent_slot = ord_rd_q[EW-1:TW];
  assign ent_time = ord_rd_q[TW-1:0];
  assign cnt_m1   = cnt_q - CW'(1);
  assign tick_due = (cnt_q != '0) && (now_q >= head_time_q);

  // after the current expiry: list shrinks to cnt_m1, head already updated
  assign last_exp = !((n_q + stq_pkg::ExpCntW'(1)) != stq_pkg::ExpCntW'(stq_pkg::MaxExp)
                      && (cnt_m1 != '0) && (now_q >= head_time_q));

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wake_mem[sidx] <= wt_q;
    end
    if (wk_re) begin
      wake_rd_q <= wake_mem[wk_raddr];
    end
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rd_q <= ord_mem[ord_raddr];
    end
  end

  assign wk_re    = accept;
  assign wk_raddr = IW'(slot_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      wt_q   <= wakeup_time_i;
      now_q  <= now_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stq_pkg::StIdle: begin
        if (accept) begin
          state_d = stq_pkg::StDecode;
        end
      end
      stq_pkg::StDecode: begin
        state_d = stq_pkg::StIdle;
        if (cmd_q == stq_pkg::CmdTick) begin
          if (tick_due) begin
            state_d = stq_pkg::StTickRd;
          end
        end else if (inrange) begin
          unique case (cmd_q)
            stq_pkg::CmdArm: begin
              if (!armed_q[sidx]) state_d = stq_pkg::StInsRd;
            end
            stq_pkg::CmdRearm: begin
              if (!armed_q[sidx] && !fired_q[sidx]) state_d = stq_pkg::StInsRd;
            end
            default: begin
              if (armed_q[sidx]) state_d = stq_pkg::StCanRd;
            end
          endcase
        end
      end
      stq_pkg::StInsRd: begin
        state_d = (pos_q == '0) ? stq_pkg::StIdle : stq_pkg::StInsChk;
      end
      stq_pkg::StInsChk: begin
        state_d = (ent_time < t_q) ? stq_pkg::StIdle : stq_pkg::StInsRd;
      end
      stq_pkg::StCanRd: begin
        state_d = (pos_q == cnt_q) ? stq_pkg::StIdle : stq_pkg::StCanChk;
      end
      stq_pkg::StCanChk: begin
        state_d = stq_pkg::StCanRd;
      end
      stq_pkg::StTickRd: begin
        if (pos_q == cnt_q) begin
          state_d = last_exp ? stq_pkg::StIdle : stq_pkg::StTickRd;
        end else begin
          state_d = stq_pkg::StTickChk;
        end
      end
      stq_pkg::StTickChk: begin
        state_d = stq_pkg::StTickRd;
      end
      default: state_d = stq_pkg::StIdle;
    endcase
  end

  // datapath and results
  always_comb begin
    t_d         = t_q;
    pos_d       = pos_q;
    found_d     = found_q;
    p0_d        = p0_q;
    n_d         = n_q;
    exp_slot_d  = exp_slot_q;
    exp_time_d  = exp_time_q;
    cnt_d       = cnt_q;
    head_slot_d = head_slot_q;
    head_time_d = head_time_q;
    armed_d     = armed_q;
    fired_d     = fired_q;
    wk_we       = 1'b0;
    ord_re      = 1'b0;
    ord_raddr   = '0;
    ord_we      = 1'b0;
    ord_waddr   = '0;
    ord_wdata   = '0;

    res_v_d      = 1'b0;
    res_status_d = stq_pkg::StOk;
    res_ev_d     = 1'b0;
    res_es_d     = '0;
    res_last_d   = 1'b1;
    res_hc_d     = 1'b0;
    res_hv_d     = (cnt_q != '0);
    res_hw_d     = head_time_q;
    res_sa_d     = 1'b0;
    res_sf_d     = 1'b0;
    res_rem_d    = '0;

    unique case (state_q)
      stq_pkg::StDecode: begin
        if (inrange) begin
          res_sa_d  = armed_q[sidx];
          res_sf_d  = fired_q[sidx];
          res_rem_d = wake_rd_q - now_q;
        end
        if (cmd_q == stq_pkg::CmdTick) begin
          if (tick_due) begin
            n_d        = '0;
            pos_d      = CW'(1);
            exp_slot_d = head_slot_q;
            exp_time_d = head_time_q;
          end else begin
            res_v_d  = 1'b1;
            res_hc_d = (cnt_q != '0);
          end
        end else if (!inrange) begin
          res_v_d      = 1'b1;
          res_status_d = stq_pkg::StNotArmed;
        end else begin
          unique case (cmd_q)
            stq_pkg::CmdArm: begin
              if (armed_q[sidx]) begin
                res_v_d      = 1'b1;
                res_status_d = stq_pkg::StArmed;
              end else begin
                wk_we = 1'b1;
                t_d   = wt_q;
                pos_d = cnt_q;
              end
            end
            stq_pkg::CmdRearm: begin
              if (armed_q[sidx]) begin
                res_v_d      = 1'b1;
                res_status_d = stq_pkg::StArmed;
              end else if (fired_q[sidx]) begin
                res_v_d      = 1'b1;
                res_status_d = stq_pkg::StFired;
              end else begin
                t_d   = wake_rd_q;
                pos_d = cnt_q;
              end
            end
            default: begin
              if (!armed_q[sidx]) begin
                res_v_d      = 1'b1;
                res_status_d = stq_pkg::StNotArmed;
              end else begin
                pos_d   = '0;
                found_d = 1'b0;
                p0_d    = 1'b0;
              end
            end
          endcase
        end
      end

      stq_pkg::StInsRd: begin
        if (pos_q == '0) begin
          ord_we       = 1'b1;
          ord_waddr    = '0;
          ord_wdata    = {sidx, t_q};
          head_slot_d  = sidx;
          head_time_d  = t_q;
          cnt_d        = cnt_q + CW'(1);
          armed_d[sidx] = 1'b1;
          res_v_d      = 1'b1;
          res_hc_d     = 1'b1;
          res_hv_d     = 1'b1;
          res_hw_d     = t_q;
          res_sa_d     = 1'b1;
          res_sf_d     = fired_q[sidx];
          res_rem_d    = t_q - now_q;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = IW'(pos_q - CW'(1));
        end
      end

      stq_pkg::StInsChk: begin
        ord_we    = 1'b1;
        ord_waddr = IW'(pos_q);
        if (ent_time < t_q) begin
          ord_wdata     = {sidx, t_q};
          cnt_d         = cnt_q + CW'(1);
          armed_d[sidx] = 1'b1;
          res_v_d       = 1'b1;
          res_hv_d      = 1'b1;
          res_sa_d      = 1'b1;
          res_sf_d      = fired_q[sidx];
          res_rem_d     = t_q - now_q;
        end else begin
          ord_wdata = ord_rd_q;
          pos_d     = pos_q - CW'(1);
        end
      end

      stq_pkg::StCanRd: begin
        if (pos_q == cnt_q) begin
          cnt_d         = cnt_m1;
          armed_d[sidx] = 1'b0;
          res_v_d       = 1'b1;
          res_hv_d      = (cnt_m1 != '0);
          res_hw_d      = (cnt_m1 != '0) ? head_time_q : '0;
          res_hc_d      = p0_q && (cnt_m1 != '0);
          res_sf_d      = fired_q[sidx];
          res_rem_d     = wake_rd_q - now_q;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = IW'(pos_q);
        end
      end

      stq_pkg::StCanChk: begin
        if (found_q) begin
          ord_we    = 1'b1;
          ord_waddr = IW'(pos_q - CW'(1));
          ord_wdata = ord_rd_q;
          if (pos_q == CW'(1)) begin
            head_slot_d = ent_slot;
            head_time_d = ent_time;
          end
        end else if (ent_slot == sidx) begin
          found_d = 1'b1;
          p0_d    = (pos_q == '0);
        end
        pos_d = pos_q + CW'(1);
      end

      stq_pkg::StTickRd: begin
        if (pos_q == cnt_q) begin
          cnt_d               = cnt_m1;
          armed_d[exp_slot_q] = 1'b0;
          fired_d[exp_slot_q] = 1'b1;
          n_d                 = n_q + stq_pkg::ExpCntW'(1);
          res_v_d             = 1'b1;
          res_ev_d            = 1'b1;
          res_es_d            = stq_pkg::SlotW'(exp_slot_q);
          res_hv_d            = (cnt_m1 != '0);
          res_hw_d            = (cnt_m1 != '0) ? head_time_q : '0;
          res_last_d          = last_exp;
          res_hc_d            = last_exp && (cnt_m1 != '0);
          res_sf_d            = 1'b1;
          res_rem_d           = exp_time_q - now_q;
          pos_d               = CW'(1);
          exp_slot_d          = head_slot_q;
          exp_time_d          = head_time_q;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = IW'(pos_q);
        end
      end

      stq_pkg::StTickChk: begin
        ord_we    = 1'b1;
        ord_waddr = IW'(pos_q - CW'(1));
        ord_wdata = ord_rd_q;
        if (pos_q == CW'(1)) begin
          head_slot_d = ent_slot;
          head_time_d = ent_time;
        end
        pos_d = pos_q + CW'(1);
      end

      default: begin
      end
    endcase

    if (!res_hv_d) begin
      res_hw_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= stq_pkg::StIdle;
      cnt_q          <= '0;
      armed_q        <= '0;
      fired_q        <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      armed_q        <= armed_d;
      fired_q        <= fired_d;
      result_valid_o <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    pos_q       <= pos_d;
    found_q     <= found_d;
    p0_q        <= p0_d;
    n_q         <= n_d;
    exp_slot_q  <= exp_slot_d;
    exp_time_q  <= exp_time_d;
    head_slot_q <= head_slot_d;
    head_time_q <= head_time_d;
    if (res_v_d) begin
      status_o        <= res_status_d;
      expired_valid_o <= res_ev_d;
      expired_slot_o  <= res_es_d;
      last_o          <= res_last_d;
      head_valid_o    <= res_hv_d;
      head_wakeup_o   <= res_hw_d;
      head_changed_o  <= res_hc_d;
      slot_armed_o    <= res_sa_d;
      slot_fired_o    <= res_sf_d;
      remaining_o     <= res_rem_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/stq_checker.sv */
`default_nettype none

module stq_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             result_valid_o,
  input wire logic [stq_pkg::StatusW-1:0]      status_o,
  input wire logic                             expired_valid_o,
  input wire logic                             last_o,
  input wire logic                             head_valid_o,
  input wire logic [stq_pkg::TimeW-1:0]        head_wakeup_o,
  input wire logic                             head_changed_o,
  input wire logic                             slot_armed_o,
  input wire logic                             slot_fired_o
);

  // a taken command always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command beat did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && expired_valid_o) |->
      (status_o == stq_pkg::StOk && !slot_armed_o && slot_fired_o))
    else $error("expiry beat with bad status or slot flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !head_valid_o) |-> (head_wakeup_o == '0 && !head_changed_o))
    else $error("empty queue reports a head");

  // a non-final beat only comes from a tick expiry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (expired_valid_o && busy))
    else $error("non-final beat outside tick expiry");

endmodule

bind sorted_timeout_queue_core stq_checker u_stq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .expired_valid_o(expired_valid_o),
  .last_o         (last_o),
  .head_valid_o   (head_valid_o),
  .head_wakeup_o  (head_wakeup_o),
  .head_changed_o (head_changed_o),
  .slot_armed_o   (slot_armed_o),
  .slot_fired_o   (slot_fired_o)
);

`default_nettype wire

/* sim/tb_sorted_timeout_queue_core.sv */
`timescale 1ns / 1ps

module tb_sorted_timeout_queue_core;

  typedef struct {
    logic [stq_pkg::StatusW-1:0] status;
    logic                        expired_valid;
    logic [stq_pkg::SlotW-1:0]   expired_slot;
    logic                        last;
    logic                        head_valid;
    logic [stq_pkg::TimeW-1:0]   head_wakeup;
    logic                        head_changed;
    logic                        slot_armed;
    logic                        slot_fired;
    logic [stq_pkg::TimeW-1:0]   remaining;
  } timer_res_t;

  class timer_scoreboard;
    logic [stq_pkg::TimeW-1:0] wake_q[32];
    bit                        armed_q[32];
    bit                        fired_q[32];
    logic [stq_pkg::SlotW-1:0] wake_order[$];
    timer_res_t                pending_res[$];
    int                        errors;

    function new();
      errors = 0;
      foreach (wake_q[i]) begin
        wake_q[i]  = '0;
        armed_q[i] = 0;
        fired_q[i] = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    function timer_res_t make_res(logic [stq_pkg::StatusW-1:0] st, bit ev,
                                  logic [stq_pkg::SlotW-1:0] es, bit hc,
                                  logic [stq_pkg::SlotW-1:0] rs,
                                  logic [stq_pkg::TimeW-1:0] now);
      timer_res_t r;
      r.status        = st;
      r.expired_valid = ev;
      r.expired_slot  = es;
      r.last          = 0;
      r.head_valid    = wake_order.size() > 0;
      r.head_wakeup   = r.head_valid ? wake_q[wake_order[0]] : '0;
      r.head_changed  = hc;
      r.slot_armed    = armed_q[rs];
      r.slot_fired    = fired_q[rs];
      r.remaining     = wake_q[rs] - now;
      return r;
    endfunction

    // new entry goes ahead of equal or later times
    function bit insert_sorted(logic [stq_pkg::SlotW-1:0] s);
      int p;
      p = 0;
      while (p < wake_order.size() && wake_q[wake_order[p]] < wake_q[s]) p++;
      wake_order.insert(p, s);
      armed_q[s] = 1;
      return p == 0;
    endfunction

    function int unlink(logic [stq_pkg::SlotW-1:0] s);
      int p;
      p = 0;
      while (p < wake_order.size() && wake_order[p] != s) p++;
      if (p < wake_order.size()) wake_order.delete(p);
      armed_q[s] = 0;
      return p;
    endfunction

    function void note_cmd(logic [stq_pkg::CmdW-1:0] cmd, logic [stq_pkg::SlotW-1:0] slot,
                           logic [stq_pkg::TimeW-1:0] wt, logic [stq_pkg::TimeW-1:0] now);
      logic [stq_pkg::StatusW-1:0] st;
      logic [stq_pkg::SlotW-1:0]   s;
      bit                          hc;
      int                          n;
      int                          p;
      st = stq_pkg::StOk;
      hc = 0;
      if (cmd == stq_pkg::CmdTick) begin
        n = 0;
        while (wake_order.size() > 0 && n < stq_pkg::MaxExp &&
               now >= wake_q[wake_order[0]]) begin
          s = wake_order[0];
          p = unlink(s);
          fired_q[s] = 1;
          pending_res.push_back(make_res(stq_pkg::StOk, 1, s, 0, s, now));
          n++;
        end
        if (n == 0) pending_res.push_back(make_res(stq_pkg::StOk, 0, '0, 0, slot, now));
        pending_res[pending_res.size()-1].head_changed = wake_order.size() > 0;
        pending_res[pending_res.size()-1].last = 1;
        return;
      end
      if (cmd == stq_pkg::CmdArm) begin
        if (armed_q[slot]) st = stq_pkg::StArmed;
        else begin
          wake_q[slot] = wt;
          hc = insert_sorted(slot);
        end
      end else if (cmd == stq_pkg::CmdRearm) begin
        if (armed_q[slot]) st = stq_pkg::StArmed;
        else if (fired_q[slot]) st = stq_pkg::StFired;
        else hc = insert_sorted(slot);
      end else begin
        if (!armed_q[slot]) st = stq_pkg::StNotArmed;
        else begin
          p = unlink(slot);
          hc = (p == 0) && (wake_order.size() > 0);
        end
      end
      pending_res.push_back(make_res(st, 0, '0, hc, slot, now));
      pending_res[pending_res.size()-1].last = 1;
    endfunction

    task check_res(timer_res_t got);
      timer_res_t e;
      if (pending_res.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending_res.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d exp %0d", got.status, e.status));
      if (got.expired_valid !== e.expired_valid)
        report($sformatf("expired_valid %0b exp %0b", got.expired_valid, e.expired_valid));
      if (got.expired_slot !== e.expired_slot)
        report($sformatf("expired_slot %0d exp %0d", got.expired_slot, e.expired_slot));
      if (got.last !== e.last)
        report($sformatf("last %0b exp %0b", got.last, e.last));
      if (got.head_valid !== e.head_valid)
        report($sformatf("head_valid %0b exp %0b", got.head_valid, e.head_valid));
      if (got.head_wakeup !== e.head_wakeup)
        report($sformatf("head_wakeup %0h exp %0h", got.head_wakeup, e.head_wakeup));
      if (got.head_changed !== e.head_changed)
        report($sformatf("head_changed %0b exp %0b", got.head_changed, e.head_changed));
      if (got.slot_armed !== e.slot_armed)
        report($sformatf("slot_armed %0b exp %0b", got.slot_armed, e.slot_armed));
      if (got.slot_fired !== e.slot_fired)
        report($sformatf("slot_fired %0b exp %0b", got.slot_fired, e.slot_fired));
      if (got.remaining !== e.remaining)
        report($sformatf("remaining %0h exp %0h", got.remaining, e.remaining));
    endtask
  endclass

  logic                        clk_i = 0;
  logic                        rst_ni = 0;
  logic                        start = 0;
  logic                        busy;
  logic [stq_pkg::CmdW-1:0]    cmd_i = '0;
  logic [stq_pkg::SlotW-1:0]   slot_i = '0;
  logic [stq_pkg::TimeW-1:0]   wakeup_time_i = '0;
  logic [stq_pkg::TimeW-1:0]   now_i = '0;
  logic                        result_valid_o;
  logic [stq_pkg::StatusW-1:0] status_o;
  logic                        expired_valid_o;
  logic [stq_pkg::SlotW-1:0]   expired_slot_o;
  logic                        last_o;
  logic                        head_valid_o;
  logic [stq_pkg::TimeW-1:0]   head_wakeup_o;
  logic                        head_changed_o;
  logic                        slot_armed_o;
  logic                        slot_fired_o;
  logic signed [stq_pkg::TimeW-1:0] remaining_o;

  timer_scoreboard sb = new();
  bit              written[32];
  int              idle_pct;
  logic [stq_pkg::TimeW-1:0] clock_now;

  sorted_timeout_queue_core DUT (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .slot_i, .wakeup_time_i, .now_i,
    .result_valid_o, .status_o, .expired_valid_o, .expired_slot_o, .last_o,
    .head_valid_o, .head_wakeup_o, .head_changed_o, .slot_armed_o, .slot_fired_o,
    .remaining_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    timer_res_t r;
    if (rst_ni && result_valid_o) begin
      r.status        = status_o;
      r.expired_valid = expired_valid_o;
      r.expired_slot  = expired_slot_o;
      r.last          = last_o;
      r.head_valid    = head_valid_o;
      r.head_wakeup   = head_wakeup_o;
      r.head_changed  = head_changed_o;
      r.slot_armed    = slot_armed_o;
      r.slot_fired    = slot_fired_o;
      r.remaining     = remaining_o;
      sb.check_res(r);
    end
  end

  function logic [stq_pkg::TimeW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one command beat, then an optional sender gap
  task send_cmd(logic [stq_pkg::CmdW-1:0] c, logic [stq_pkg::SlotW-1:0] s,
                logic [stq_pkg::TimeW-1:0] wt, logic [stq_pkg::TimeW-1:0] now);
    start         <= 1'b1;
    cmd_i         <= c;
    slot_i        <= s;
    wakeup_time_i <= wt;
    now_i         <= now;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(c, s, wt, now);
    if (c == stq_pkg::CmdArm) written[s] = 1;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd_i <= stq_pkg::CmdW'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // only slots whose time was written may be addressed by non-arm commands
  function logic [stq_pkg::SlotW-1:0] pick_written();
    logic [stq_pkg::SlotW-1:0] s;
    s = stq_pkg::SlotW'($urandom);
    while (!written[s]) s = stq_pkg::SlotW'($urandom);
    return s;
  endfunction

  task random_item();
    int k;
    logic [stq_pkg::SlotW-1:0] s;
    k = $urandom_range(99);
    if (k < 45 || !written[0] && !written[31] && k < 60) begin
      s = stq_pkg::SlotW'($urandom);
      if (k < 5) send_cmd(stq_pkg::CmdArm, s, rand64(), rand64());
      else send_cmd(stq_pkg::CmdArm, s, clock_now + 64'($urandom_range(0, 300)), clock_now);
    end else begin
      s = pick_written();
      if (k < 60) send_cmd(stq_pkg::CmdRearm, s, rand64(), clock_now);
      else if (k < 72) send_cmd(stq_pkg::CmdCancel, s, rand64(), clock_now);
      else if (k < 76) send_cmd(stq_pkg::CmdTick, s, rand64(), rand64());
      else begin
        clock_now = clock_now + 64'($urandom_range(0, 150));
        send_cmd(stq_pkg::CmdTick, s, rand64(), clock_now);
      end
    end
  endtask

  initial begin
    logic [stq_pkg::TimeW-1:0] ones;
    foreach (written[i]) written[i] = 0;
    ones = '1;
    idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(stq_pkg::CmdArm, 5'd0, 64'd100, 64'd0);
    send_cmd(stq_pkg::CmdArm, 5'd31, ones, 64'd0);
    send_cmd(stq_pkg::CmdArm, 5'd7, 64'd100, 64'd0);    // tie goes ahead of slot 0
    send_cmd(stq_pkg::CmdArm, 5'd0, 64'd5, 64'd0);      // already armed
    send_cmd(stq_pkg::CmdRearm, 5'd7, 64'd0, 64'd0);
    send_cmd(stq_pkg::CmdCancel, 5'd7, 64'd0, 64'd0);   // head cancel, others remain
    send_cmd(stq_pkg::CmdCancel, 5'd7, 64'd0, 64'd0);   // not armed
    send_cmd(stq_pkg::CmdRearm, 5'd7, 64'd0, 64'd0);
    send_cmd(stq_pkg::CmdTick, 5'd7, 64'd0, 64'd99);    // nothing due
    send_cmd(stq_pkg::CmdTick, 5'd0, 64'd0, 64'd100);
    send_cmd(stq_pkg::CmdRearm, 5'd0, 64'd0, 64'd0);    // fired, stays ignored
    send_cmd(stq_pkg::CmdArm, 5'd0, 64'd0, ones);       // explicit arm after fire
    send_cmd(stq_pkg::CmdTick, 5'd31, ones, ones);
    send_cmd(stq_pkg::CmdTick, 5'd31, ones, 64'd0);     // empty queue
    send_cmd(stq_pkg::CmdArm, 5'd15, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(stq_pkg::CmdArm, 5'd16, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_cmd(stq_pkg::CmdCancel, 5'd16, 64'd0, 64'd0);
    send_cmd(stq_pkg::CmdCancel, 5'd15, 64'd0, 64'd0);  // last one, no reprogram
    for (int i = 0; i < 32; i++)
      send_cmd(stq_pkg::CmdArm, stq_pkg::SlotW'(i), 64'(1000 - (i % 5) * 7), 64'd0);
    send_cmd(stq_pkg::CmdTick, 5'd9, 64'd0, 64'd2000);  // all 32 expire at once

    clock_now = 64'd2000;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : (ph == 1) ? 63 : 0;
      for (int n = 0; n < 60; n++) random_item();
    end
    start <= 1'b0;

    while (sb.pending_res.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_res.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
